@@ rtl/ima_pkg.sv @@
// Shared types and constants for the impedance magnitude averager.
`timescale 1ns / 1ps

package ima_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_AVERAGE_COUNT = 2'd0;
	localparam logic [1:0] CFG_INVERSE_GAIN  = 2'd1;

	localparam int CFG_IDX_W   = 2;
	localparam int SAMPLE_W    = 16;
	localparam int COUNT_W     = 8;
	localparam int SCALE_W     = 40;
	localparam int SUM_W       = 48;
	localparam int ALU_W       = 32;
	localparam int ROOT_W      = 16;

	// Iteration counts of the shared compare/subtract unit
	localparam int SQRT_STEPS  = 16;
	localparam int TERM_STEPS  = 40;
	localparam int AVG_STEPS   = 48;
	localparam int STEP_W      = 6;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 40'd256;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_SQ_ADD,
		ST_SQRT,
		ST_DIV_TERM,
		ST_ACC,
		ST_DIV_AVG,
		ST_EMIT
	} ima_state_t;

	typedef struct packed {
		logic [SCALE_W-1:0] impedance;
		logic               timeout_flag;
	} ima_res_t;

endpackage

@@ rtl/ima_alu.sv @@
// Shared compare/subtract unit used by the square root and both divisions.
`timescale 1ns / 1ps

module ima_alu (
	input  logic [ima_pkg::ALU_W-1:0] a,
	input  logic [ima_pkg::ALU_W-1:0] b,
	output logic [ima_pkg::ALU_W-1:0] diff,
	output logic                      ge
);
	import ima_pkg::*;

	logic [ALU_W:0] wide_diff;

	assign wide_diff = {1'b0, a} - {1'b0, b};
	assign diff      = wide_diff[ALU_W-1:0];
	assign ge        = ~wide_diff[ALU_W];

endmodule

@@ rtl/ima_engine.sv @@
// Sequencer and working registers: square, integer sqrt, divides, accumulate.
`timescale 1ns / 1ps

module ima_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ima_pkg::SAMPLE_W-1:0]  real_part,
	input  logic [ima_pkg::SAMPLE_W-1:0]  imag_part,
	input  logic                          not_ready,
	input  logic [ima_pkg::SCALE_W-1:0]   scale,
	input  logic [ima_pkg::COUNT_W-1:0]   eff_cnt,
	output logic                          idle,
	output logic                          res_valid,
	input  logic                          res_ready,
	output ima_pkg::ima_res_t             res
);
	import ima_pkg::*;

	ima_state_t state_q, state_d;

	logic [STEP_W-1:0]   step_q;
	logic [SUM_W-1:0]    term_sum_q;
	logic [COUNT_W-1:0]  samples_q;

	logic [SAMPLE_W-1:0] re_abs_q, im_abs_q;
	logic [ALU_W-1:0]    prod_q;
	logic [ALU_W-1:0]    rem_q;
	logic [ALU_W-1:0]    root_q;
	logic [SUM_W-1:0]    quo_q;
	logic [SCALE_W-1:0]  res_imp_q;
	logic                res_to_q;

	logic [SAMPLE_W-1:0] mul_in;
	logic [ALU_W-1:0]    prod;
	logic [ALU_W-1:0]    bit_val;
	logic [ALU_W-1:0]    alu_a, alu_b, alu_diff;
	logic                alu_ge;
	logic [ALU_W-1:0]    root_nx, rem_nx;
	logic [SUM_W-1:0]    quo_nx;
	logic [SUM_W:0]      sum_acc;
	logic [SUM_W-1:0]    sum_sat;
	logic [COUNT_W:0]    samples_inc;
	logic                avg_due;
	logic                step_last;

	// One 16x16 squarer, shared between the two components
	assign mul_in = (state_q == ST_SQ_RE) ? re_abs_q : im_abs_q;
	assign prod   = {{(ALU_W-SAMPLE_W){1'b0}}, mul_in} * {{(ALU_W-SAMPLE_W){1'b0}}, mul_in};

	// sqrt bit weight 4^step; root and bit never overlap, so OR is the add
	assign bit_val = {{(ALU_W-1){1'b0}}, 1'b1} << {step_q[3:0], 1'b0};

	always_comb begin
		if (state_q == ST_SQRT) begin
			alu_a = rem_q;
			alu_b = root_q | bit_val;
		end else begin
			alu_a = {rem_q[ALU_W-2:0], quo_q[SUM_W-1]};
			alu_b = (state_q == ST_DIV_TERM) ? root_q
				: {{(ALU_W-COUNT_W){1'b0}}, eff_cnt};
		end
	end

	ima_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	assign root_nx   = alu_ge ? ((root_q >> 1) | bit_val) : (root_q >> 1);
	assign rem_nx    = alu_ge ? alu_diff : alu_a;
	assign quo_nx    = {quo_q[SUM_W-2:0], alu_ge};
	assign step_last = (step_q == '0);

	assign sum_acc     = {1'b0, term_sum_q} + {{(SUM_W-SCALE_W+1){1'b0}}, quo_q[SCALE_W-1:0]};
	assign sum_sat     = sum_acc[SUM_W] ? {SUM_W{1'b1}} : sum_acc[SUM_W-1:0];
	assign samples_inc = {1'b0, samples_q} + {{COUNT_W{1'b0}}, 1'b1};
	assign avg_due     = (samples_inc >= {1'b0, eff_cnt});

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = not_ready ? ST_EMIT : ST_SQ_RE;
			end
			ST_SQ_RE:  state_d = ST_SQ_IM;
			ST_SQ_IM:  state_d = ST_SQ_ADD;
			ST_SQ_ADD: state_d = ST_SQRT;
			ST_SQRT: begin
				if (step_last) state_d = (root_nx == '0) ? ST_ACC : ST_DIV_TERM;
			end
			ST_DIV_TERM: begin
				if (step_last) state_d = ST_ACC;
			end
			ST_ACC: state_d = avg_due ? ST_DIV_AVG : ST_IDLE;
			ST_DIV_AVG: begin
				if (step_last) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		idle             = (state_q == ST_IDLE);
		res_valid        = (state_q == ST_EMIT);
		res.impedance    = res_imp_q;
		res.timeout_flag = res_to_q;
	end

	// Control state and running average
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			term_sum_q <= '0;
			samples_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (start && not_ready) begin
						term_sum_q <= '0;
						samples_q  <= '0;
					end
				end
				ST_SQ_ADD: step_q <= STEP_W'(SQRT_STEPS - 1);
				ST_SQRT: begin
					step_q <= step_last ? STEP_W'(TERM_STEPS - 1) : step_q - 1'b1;
				end
				ST_DIV_TERM: step_q <= step_q - 1'b1;
				ST_ACC: begin
					step_q <= STEP_W'(AVG_STEPS - 1);
					if (avg_due) begin
						term_sum_q <= '0;
						samples_q  <= '0;
					end else begin
						term_sum_q <= sum_sat;
						samples_q  <= samples_inc[COUNT_W-1:0];
					end
				end
				ST_DIV_AVG: step_q <= step_q - 1'b1;
				default: ;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					re_abs_q  <= real_part[SAMPLE_W-1] ? (~real_part + 1'b1) : real_part;
					im_abs_q  <= imag_part[SAMPLE_W-1] ? (~imag_part + 1'b1) : imag_part;
					res_imp_q <= '0;
					res_to_q  <= not_ready;
				end
			end
			ST_SQ_RE: rem_q  <= prod;
			ST_SQ_IM: prod_q <= prod;
			ST_SQ_ADD: begin
				rem_q  <= rem_q + prod_q;
				root_q <= '0;
			end
			ST_SQRT: begin
				root_q <= root_nx;
				if (step_last) begin
					rem_q <= '0;
					quo_q <= (root_nx == '0) ? '0 : {scale, {(SUM_W-SCALE_W){1'b0}}};
				end else begin
					rem_q <= alu_ge ? alu_diff : rem_q;
				end
			end
			ST_DIV_TERM: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
			end
			ST_ACC: begin
				rem_q <= '0;
				quo_q <= sum_sat;
			end
			ST_DIV_AVG: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (step_last) begin
					res_imp_q <= (quo_nx[SUM_W-1:SCALE_W] != '0) ? {SCALE_W{1'b1}}
						: quo_nx[SCALE_W-1:0];
					res_to_q  <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	// Term division never runs with a zero magnitude
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV_TERM |-> root_q != '0)
		else $error("term division with zero divisor");

	// Restoring remainder stays below the magnitude
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV_TERM |-> rem_q < root_q)
		else $error("division remainder out of range");

	// A timeout item goes straight to a zero, flagged result with state cleared
	a_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start && not_ready) |=>
		(state_q == ST_EMIT && res_to_q && res_imp_q == '0 && samples_q == '0))
		else $error("timeout item handled wrong");

	// A flagged result always carries zero impedance
	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && res_to_q) |-> res_imp_q == '0)
		else $error("timeout result with nonzero impedance");

endmodule

@@ rtl/impedance_magnitude_averager.sv @@
// Top level: handshakes, configuration registers and output register.
`timescale 1ns / 1ps

// Impedance magnitude averager.
// Input channel (in_valid/in_ready) takes one signed real/imag DFT pair per
// item, or a timeout mark (not_ready = 1). Each pair is reduced to its
// integer magnitude sqrt(re^2 + im^2); inverse_gain_scale / magnitude is added
// to a saturating running sum. After average_count samples the block emits
// the sum divided by the count (Q32.8 ohms, saturated to 40 bits) and clears.
// A timeout item emits impedance 0 with timeout_flag set and clears the sum.
// Rate: one item at a time on a single shared compare/subtract unit.
// A timeout goes from acceptance straight to the emit state. A sample runs 3
// squaring states, 16 sqrt steps, 40 term divide steps and 1 accumulate state
// (a zero magnitude skips the divide). A sample that completes an average adds
// 48 divide steps and the emit state; out_valid rises at the same edge at which
// in_ready comes back.
// in_ready is high only while the sequencer is idle. A finished result sits
// in the output register; if the receiver stalls, the next item is still
// processed and its result waits in the sequencer until the register frees.
// Configuration (cfg_valid/cfg_ready, always ready) is to be written while idle;
// the block does not enforce this. Index 0 average_count (0 acts as 1), index 1
// inverse_gain_scale, others ignored. Reset clears the running sum, count and
// output valid, and loads average_count = 1 and inverse_gain_scale = 1.0.
module impedance_magnitude_averager #(
	parameter int MAX_AVERAGE = 255
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [ima_pkg::SAMPLE_W-1:0] real_part,
	input  logic signed [ima_pkg::SAMPLE_W-1:0] imag_part,
	input  logic                          not_ready,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ima_pkg::SCALE_W-1:0]   impedance,
	output logic                          timeout_flag,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ima_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ima_pkg::SCALE_W-1:0]   cfg_data
);
	import ima_pkg::*;

	localparam logic [16:0] MaxAvg = 17'(MAX_AVERAGE);

	logic [COUNT_W-1:0] avg_count_q;
	logic [SCALE_W-1:0] inv_scale_q;
	logic [COUNT_W-1:0] cnt_nz;
	logic [COUNT_W-1:0] eff_cnt;

	logic               eng_idle;
	logic               res_valid;
	logic               res_ready;
	ima_res_t           res;

	logic               out_valid_q;
	logic [SCALE_W-1:0] impedance_q;
	logic               timeout_q;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_count_q <= COUNT_RESET;
			inv_scale_q <= SCALE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_AVERAGE_COUNT: avg_count_q <= cfg_data[COUNT_W-1:0];
				CFG_INVERSE_GAIN:  inv_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective count: zero acts as one, clamp to the build-time maximum
	assign cnt_nz  = (avg_count_q == '0) ? {{(COUNT_W-1){1'b0}}, 1'b1} : avg_count_q;
	assign eff_cnt = ({9'b0, cnt_nz} > MaxAvg) ? MaxAvg[COUNT_W-1:0] : cnt_nz;

	assign in_ready = eng_idle;

	ima_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && eng_idle),
		.real_part (real_part),
		.imag_part (imag_part),
		.not_ready (not_ready),
		.scale     (inv_scale_q),
		.eff_cnt   (eff_cnt),
		.idle      (eng_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: frees the sequencer while the receiver stalls
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			impedance_q <= res.impedance;
			timeout_q   <= res.timeout_flag;
		end
	end

	assign out_valid    = out_valid_q;
	assign impedance    = impedance_q;
	assign timeout_flag = timeout_q;

endmodule

@@ bench/impedance_magnitude_averager_tb.sv @@
// Self-checking testbench for the impedance magnitude averager.
`timescale 1ns / 1ps

// Drives DFT pairs and timeout marks into the averager. Every accepted item is
// run through a predictor that keeps its own running sum, sample count and
// register copies. Each expected reading goes into a queue, and every result
// the block hands out is compared against the head of that queue.
//
// Stimulus comes in two parts:
//  - a short directed table: field extremes, zero magnitude, timeouts with and
//    without a partial average, zero/max count, count lowered mid-average,
//    zero/max gain scale and writes to unused register indexes. Rows whose
//    reading is obvious carry it typed in; the rest rely on the predictor.
//  - random phases: each phase waits for the block to go idle, rewrites the
//    registers, then sends a burst of items of mixed size and shape.
// Both sides idle at random. In the first random phase the sink holds off for
// a long stretch so the output register and the sequencer both fill and the
// input stalls.
module impedance_magnitude_averager_tb;
	import ima_pkg::*;

	localparam int MAX_AVERAGE   = 255;
	localparam int RANDOM_ITEMS  = 1800;
	// Long enough for the block to finish a sample that closes no average.
	localparam int SETTLE_CYCLES = 150;
	localparam int TAIL_CYCLES   = 200;
	localparam int CYCLE_LIMIT   = 3_000_000;
	localparam int HOLD_OFF_LEN  = 600;
	localparam int MAX_REPORTS   = 100;

	// Register indexes the block does not decode
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                   kind;
		logic [CFG_IDX_W-1:0]        index;
		logic [SCALE_W-1:0]          data;
		logic signed [SAMPLE_W-1:0]  re;
		logic signed [SAMPLE_W-1:0]  im;
		logic                        nr;
		bit                          typed;
		ima_res_t                    want;
	} stim_row_t;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic signed [SAMPLE_W-1:0]  real_part;
	logic signed [SAMPLE_W-1:0]  imag_part;
	logic                        not_ready;
	logic                        out_valid;
	logic                        out_ready;
	logic [SCALE_W-1:0]          impedance;
	logic                        timeout_flag;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [SCALE_W-1:0]          cfg_data;

	// Predictor state: register copies plus the running average
	logic [COUNT_W-1:0]  count_setting;
	logic [SCALE_W-1:0]  gain_setting;
	logic [SUM_W-1:0]    running_sum;
	logic [COUNT_W-1:0]  samples_in_sum;

	ima_res_t  pending_readings[$];
	int        error_count       = 0;
	int        cycle_count       = 0;
	int        hold_off_request  = 0;
	bit        quiet_source      = 0;
	bit        steady_sink       = 0;

	impedance_magnitude_averager #(
		.MAX_AVERAGE(MAX_AVERAGE)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.real_part   (real_part),
		.imag_part   (imag_part),
		.not_ready   (not_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.impedance   (impedance),
		.timeout_flag(timeout_flag),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Floor square root, one result bit at a time from the top.
	function automatic logic [ROOT_W-1:0] floor_root(input logic [ALU_W-1:0] n);
		logic [ROOT_W-1:0] root;
		logic [ROOT_W-1:0] trial;
		root = '0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			trial = root | (16'd1 << b);
			if (64'(trial) * 64'(trial) <= 64'(n))
				root = trial;
		end
		return root;
	endfunction

	// Advances the running average by one item. Returns 1 when the item
	// closes an average (or is a timeout) and fills in the reading.
	function automatic bit average_impedance_step(
		input  logic signed [SAMPLE_W-1:0] re,
		input  logic signed [SAMPLE_W-1:0] im,
		input  logic                       nr,
		output ima_res_t                   reading
	);
		longint             sre;
		longint             sim;
		logic [ALU_W-1:0]   power;
		logic [ROOT_W-1:0]  mag;
		logic [SUM_W-1:0]   term;
		logic [SUM_W:0]     wide_sum;
		logic [SUM_W-1:0]   quotient;
		int                 need;
		reading = '0;
		// timeout: abort whatever was accumulated, flag a zero reading
		if (nr) begin
			running_sum    = '0;
			samples_in_sum = '0;
			reading.timeout_flag = 1'b1;
			return 1'b1;
		end
		sre   = re;
		sim   = im;
		power = 32'(sre * sre + sim * sim);
		mag   = floor_root(power);
		// zero magnitude still counts as a sample, it just adds nothing
		term  = (mag == '0) ? '0 : 48'(gain_setting) / 48'(mag);
		wide_sum = {1'b0, running_sum} + {1'b0, term};
		running_sum = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
		samples_in_sum++;
		// count of zero means one; clamp to the build-time maximum
		need = (count_setting == '0) ? 1 : int'(count_setting);
		if (need > MAX_AVERAGE)
			need = MAX_AVERAGE;
		// >= so a count lowered mid-average closes at the next sample
		if (int'(samples_in_sum) < need)
			return 1'b0;
		quotient = running_sum / 48'(need);
		reading.impedance = (quotient > 48'(SCALE_MAX)) ? SCALE_MAX : quotient[SCALE_W-1:0];
		running_sum    = '0;
		samples_in_sum = '0;
		return 1'b1;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 16);
		return $urandom_range(40, 160);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_component();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return SAMPLE_W'($urandom);
		if (r < 7)
			return SAMPLE_W'(int'($urandom_range(0, 32)) - 16);
		if (r < 9)
			return SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
		case ($urandom_range(0, 4))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return 16'sh0001;
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return 8'd255;
		if (r < 5)
			return COUNT_W'($urandom_range(9, 40));
		return COUNT_W'($urandom_range(1, 8));
	endfunction

	function automatic logic [SCALE_W-1:0] pick_scale();
		logic [63:0] w;
		int          r;
		w = {$urandom, $urandom};
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return SCALE_MAX;
		if (r == 2)
			return SCALE_RESET;
		if (r < 6)
			return SCALE_W'($urandom_range(1, 1 << 24));
		return w[SCALE_W-1:0];
	endfunction

	function automatic stim_row_t item_row(
		input logic signed [SAMPLE_W-1:0] re,
		input logic signed [SAMPLE_W-1:0] im,
		input logic                       nr,
		input bit                         typed,
		input logic [SCALE_W-1:0]         imp,
		input logic                       flag
	);
		stim_row_t row;
		row.kind  = ROW_ITEM;
		row.index = '0;
		row.data  = '0;
		row.re    = re;
		row.im    = im;
		row.nr    = nr;
		row.typed = typed;
		row.want.impedance    = imp;
		row.want.timeout_flag = flag;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(
		input logic [CFG_IDX_W-1:0] index,
		input logic [SCALE_W-1:0]   data
	);
		stim_row_t row;
		row       = item_row('0, '0, 1'b0, 1'b0, '0, 1'b0);
		row.kind  = ROW_CFG;
		row.index = index;
		row.data  = data;
		return row;
	endfunction

	// Lower both valids and wait until every reading is in, then give the
	// block time to finish a sample that closes no average.
	task automatic settle_block();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high so back-to-back writes never drop it and raise it
	// in one step; settle_block and offer_item lower it.
	task automatic write_register(
		input logic [CFG_IDX_W-1:0] index,
		input logic [SCALE_W-1:0]   data
	);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			CFG_AVERAGE_COUNT: count_setting = data[COUNT_W-1:0];
			CFG_INVERSE_GAIN:  gain_setting  = data;
			default: ;
		endcase
	endtask

	// Offers one item and predicts its reading once it is taken. in_valid
	// stays high after acceptance; the next call lowers it only for a gap.
	task automatic offer_item(
		input logic signed [SAMPLE_W-1:0] re,
		input logic signed [SAMPLE_W-1:0] im,
		input logic                       nr,
		input bit                         typed,
		input ima_res_t                   typed_reading
	);
		int       gap;
		ima_res_t reading;
		bit       closes;
		cfg_valid <= 1'b0;
		gap = quiet_source ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		real_part <= re;
		imag_part <= im;
		not_ready <= nr;
		do @(posedge clk); while (!in_ready);
		closes = average_impedance_step(re, im, nr, reading);
		if (typed)
			pending_readings.push_back(typed_reading);
		else if (closes)
			pending_readings.push_back(reading);
	endtask

	task automatic check_reading();
		ima_res_t want;
		if (pending_readings.size() == 0) begin
			if (error_count < MAX_REPORTS)
				$display("%0t: unexpected result impedance=%0d timeout_flag=%0b",
					$time, impedance, timeout_flag);
			error_count++;
		end else begin
			want = pending_readings.pop_front();
			if (impedance !== want.impedance) begin
				if (error_count < MAX_REPORTS)
					$display("%0t: impedance mismatch: expected %0d, actual %0d",
						$time, want.impedance, impedance);
				error_count++;
			end
			if (timeout_flag !== want.timeout_flag) begin
				if (error_count < MAX_REPORTS)
					$display("%0t: timeout_flag mismatch: expected %0b, actual %0b",
						$time, want.timeout_flag, timeout_flag);
				error_count++;
			end
		end
	endtask

	// Result side: random stalls, plus a long hold-off on request.
	initial begin : result_sink
		int stall_left;
		int run_left;
		stall_left = 0;
		run_left   = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				check_reading();
			if (hold_off_request > 0) begin
				stall_left       = hold_off_request;
				hold_off_request = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (run_left > 0) begin
					run_left--;
				end else begin
					run_left   = $urandom_range(0, 24);
					stall_left = steady_sink ? 0 : pick_gap();
				end
			end
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles", $time, cycle_count);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		stim_row_t directed_rows[$];
		int        random_items;
		int        phase;
		int        phase_len;
		in_valid  <= 1'b0;
		real_part <= '0;
		imag_part <= '0;
		not_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;

		count_setting  = COUNT_RESET;
		gain_setting   = SCALE_RESET;
		running_sum    = '0;
		samples_in_sum = '0;

		// reset values: count 1, scale 1.0 (256)
		directed_rows.push_back(item_row(16'sd3, 16'sd4, 1'b0, 1'b1, 40'd51, 1'b0));
		// zero magnitude
		directed_rows.push_back(item_row(16'sd0, 16'sd0, 1'b0, 1'b1, 40'd0, 1'b0));
		// timeout with nothing accumulated; components ignored
		directed_rows.push_back(item_row(-16'sd32768, 16'sd32767, 1'b1, 1'b1, 40'd0, 1'b1));
		// largest possible magnitude
		directed_rows.push_back(item_row(-16'sd32768, -16'sd32768, 1'b0, 1'b1, 40'd0, 1'b0));
		directed_rows.push_back(item_row(16'sd32767, 16'sd0, 1'b0, 1'b1, 40'd0, 1'b0));
		directed_rows.push_back(item_row(16'sd1, 16'sd0, 1'b0, 1'b1, 40'd256, 1'b0));
		directed_rows.push_back(item_row(16'sd0, -16'sd32768, 1'b0, 1'b1, 40'd0, 1'b0));
		// full-scale gain: unit magnitude gives the 40-bit maximum
		directed_rows.push_back(cfg_row(CFG_INVERSE_GAIN, SCALE_MAX));
		directed_rows.push_back(item_row(16'sd1, -16'sd1, 1'b0, 1'b1, SCALE_MAX, 1'b0));
		directed_rows.push_back(item_row(16'sd0, 16'sd1, 1'b0, 1'b1, SCALE_MAX, 1'b0));
		directed_rows.push_back(item_row(16'sd32767, 16'sd32767, 1'b0, 1'b0, '0, 1'b0));
		// max count, then a timeout aborts the partial average
		directed_rows.push_back(cfg_row(CFG_AVERAGE_COUNT, 40'd255));
		directed_rows.push_back(item_row(-16'sd300, 16'sd400, 1'b0, 1'b0, '0, 1'b0));
		directed_rows.push_back(item_row(16'sd7, -16'sd24, 1'b0, 1'b0, '0, 1'b0));
		directed_rows.push_back(item_row(16'sd0, 16'sd0, 1'b1, 1'b1, 40'd0, 1'b1));
		// count lowered from 3 to 1 with two samples already in
		directed_rows.push_back(cfg_row(CFG_AVERAGE_COUNT, 40'd3));
		directed_rows.push_back(item_row(16'sd100, -16'sd5, 1'b0, 1'b0, '0, 1'b0));
		directed_rows.push_back(item_row(-16'sd1, -16'sd1, 1'b0, 1'b0, '0, 1'b0));
		directed_rows.push_back(cfg_row(CFG_AVERAGE_COUNT, 40'd1));
		directed_rows.push_back(item_row(16'sd12, 16'sd5, 1'b0, 1'b0, '0, 1'b0));
		// count of zero behaves as one: (2^40-1)/5
		directed_rows.push_back(cfg_row(CFG_AVERAGE_COUNT, 40'd0));
		directed_rows.push_back(item_row(16'sd3, 16'sd4, 1'b0, 1'b1, 40'd219902325555, 1'b0));
		// unused indexes must not disturb either register
		directed_rows.push_back(cfg_row(CFG_SPARE_A, 40'h12_3456_789a));
		directed_rows.push_back(cfg_row(CFG_SPARE_B, 40'haa_5555_aaaa));
		directed_rows.push_back(item_row(16'sd3, 16'sd4, 1'b0, 1'b1, 40'd219902325555, 1'b0));
		// zero gain scale
		directed_rows.push_back(cfg_row(CFG_INVERSE_GAIN, 40'd0));
		directed_rows.push_back(item_row(-16'sd5, 16'sd12, 1'b0, 1'b1, 40'd0, 1'b0));
		directed_rows.push_back(cfg_row(CFG_INVERSE_GAIN, SCALE_RESET));
		directed_rows.push_back(item_row(16'sd0, 16'sd0, 1'b1, 1'b1, 40'd0, 1'b1));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				settle_block();
				write_register(directed_rows[i].index, directed_rows[i].data);
			end else begin
				offer_item(directed_rows[i].re, directed_rows[i].im, directed_rows[i].nr,
					directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// Random phases. Config changes land at arbitrary points of a partial
		// average, so raised and lowered counts mid-average both come up.
		random_items = 0;
		phase        = 0;
		while (random_items < RANDOM_ITEMS) begin
			settle_block();
			write_register(CFG_AVERAGE_COUNT, (phase == 0) ? 40'd1 : 40'(pick_count()));
			if ($urandom_range(0, 1) == 1)
				write_register(CFG_INVERSE_GAIN, pick_scale());
			if ($urandom_range(0, 7) == 0)
				write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, pick_scale());
			quiet_source = ($urandom_range(0, 3) == 0);
			steady_sink  = ($urandom_range(0, 3) == 0);
			// first phase: back-to-back items against a long sink stall so the
			// output register and the sequencer fill and in_ready drops
			if (phase == 0) begin
				quiet_source     = 1'b1;
				hold_off_request = HOLD_OFF_LEN;
			end
			phase_len = $urandom_range(20, 150);
			repeat (phase_len) begin
				offer_item(pick_component(), pick_component(),
					($urandom_range(0, 39) == 0), 1'b0, '0);
			end
			random_items += phase_len;
			phase++;
		end

		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
